[rtl/ipds_pkg.sv]
// Shared types and constants for the image pair difference statistics unit.
// No dependencies; every other file in rtl/ imports this package.
package ipds_pkg;

  localparam int IDX_W    = 24;              // pixel index width
  localparam int CNT_W    = IDX_W + 1;       // counters hold up to 2^IDX_W
  localparam int PIX_W    = 16;
  localparam int SUM_W    = 40;
  localparam int FRAC_W   = 8;               // fraction bits of the mean
  localparam int DVD_W    = SUM_W + FRAC_W;  // dividend width of the mean
  localparam int MEAN_W   = 24;
  localparam int DIVC_W   = $clog2(DVD_W);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(1) << IDX_W;

  // Running totals of one image, also the entry format of the totals queue.
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] dcount;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] maxd;
    logic             found;
    logic [IDX_W-1:0] first_idx;
    logic [PIX_W-1:0] first_a;
    logic [PIX_W-1:0] first_b;
    logic             ovf;
  } stats_t;

endpackage

[rtl/ipds_front.sv]
// Front end: accumulates per-image difference stats, one pair a cycle when accepted.
// Depends on ipds_pkg; emits a totals snapshot on the last pair of an image.
module ipds_front import ipds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel_a,
  input  logic [PIX_W-1:0] pixel_b,
  input  logic             last_pixel,
  output logic             snap_push,
  output stats_t           snap
);

  stats_t           st_r, st_nxt, cur;
  logic [PIX_W-1:0] diff;
  logic             nz;
  logic             sat;
  logic [IDX_W-1:0] idx;
  logic [SUM_W:0]   sum_add;

  always_comb begin
    diff    = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
    nz      = |diff;
    sat     = (st_r.total == CAP);
    idx     = sat ? {IDX_W{1'b1}} : st_r.total[IDX_W-1:0];
    sum_add = (SUM_W+1)'(st_r.sum) + (SUM_W+1)'(diff);

    cur       = st_r;
    cur.total = sat ? st_r.total : st_r.total + CNT_W'(1);
    if (sat) cur.ovf = 1'b1;
    if (nz) begin
      if (sum_add[SUM_W]) begin
        cur.sum = {SUM_W{1'b1}};
        cur.ovf = 1'b1;
      end else begin
        cur.sum = sum_add[SUM_W-1:0];
      end
      if (diff > st_r.maxd) cur.maxd = diff;
      if (st_r.dcount == CAP) cur.ovf = 1'b1;
      else cur.dcount = st_r.dcount + CNT_W'(1);
      if (!st_r.found) begin
        cur.found     = 1'b1;
        cur.first_idx = idx;
        cur.first_a   = pixel_a;
        cur.first_b   = pixel_b;
      end
    end

    st_nxt = st_r;
    if (accept) st_nxt = last_pixel ? '0 : cur;
  end

  assign snap_push = accept && last_pixel;
  assign snap      = cur;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else st_r <= st_nxt;
  end

endmodule

[rtl/ipds_queue.sv]
// Two-entry queue of image totals between the front end and the divider.
// Depends on ipds_pkg for stats_t and the queue depth.
module ipds_queue import ipds_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  stats_t push_data,
  output logic   full,
  input  logic   pop,
  output stats_t pop_data,
  output logic   empty
);

  stats_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[rtl/ipds_back.sv]
// Back end: restoring divider for the Q16.8 mean, one quotient bit a cycle,
// and the result register. Depends on ipds_pkg.
module ipds_back import ipds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  stats_t            q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output stats_t            res,
  output logic [MEAN_W-1:0] res_mean
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [DIVC_W-1:0] cnt_r;
  stats_t            hold_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MEAN_W-1:0] quo_r;
  logic              out_valid_r, out_valid_nxt;
  stats_t            res_r;
  logic [MEAN_W-1:0] mean_r;

  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic              load_out;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - (CNT_W+1)'(hold_r.dcount);
  assign ge      = (rem_sh >= (CNT_W+1)'(hold_r.dcount));

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Divider datapath: load on pop, shift one bit per cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold_r <= q_data;
      dvd_r  <= {q_data.sum, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= DIVC_W'(DVD_W - 1);
    end else if (state_r == ST_DIV) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[MEAN_W-2:0], ge};
      cnt_r <= cnt_r - DIVC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r  <= hold_r;
      mean_r <= (hold_r.dcount == '0) ? '0 : quo_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign res       = res_r;
  assign res_mean  = mean_r;

endmodule

[rtl/image_pair_difference_stats_unit.sv]
// Image pair difference statistics: top level joining front end, totals queue
// and divider back end. Depends on ipds_pkg, ipds_front, ipds_queue, ipds_back.
//
// Usage: push one pair of 16-bit pixels per cycle in raster order, with
// in_last_pixel high on the final pair of an image. Pairs are taken at one
// per cycle while in_full is low; the accumulators (pair count, sum of
// absolute differences, max, differing count, first difference) update as
// each pair is taken. The last pair of an image moves a snapshot of the totals
// into a two-entry queue and clears the accumulators, so the next image can
// start on the following cycle if the queue has room. The back end takes the
// entry and computes the mean as floor(256 * sum / differing_count) with a
// restoring divider, one quotient bit per cycle, then loads the result
// register once it is free. in_full rises only when both queue entries wait
// on the back end, i.e. when images arrive faster than they drain. Counters
// saturate at 2^24 pairs and the sum at 2^40 - 1, each setting out_overflow.
module image_pair_difference_stats_unit import ipds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // pixel pair input
  input  logic              in_push,
  output logic              in_full,
  input  logic [PIX_W-1:0]  in_pixel_a,
  input  logic [PIX_W-1:0]  in_pixel_b,
  input  logic              in_last_pixel,
  // result output
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CNT_W-1:0]  out_total_pixels,
  output logic [CNT_W-1:0]  out_differing_count,
  output logic [MEAN_W-1:0] out_mean_difference,
  output logic [PIX_W-1:0]  out_max_difference,
  output logic              out_any_difference,
  output logic [IDX_W-1:0]  out_first_index,
  output logic [PIX_W-1:0]  out_first_value_a,
  output logic [PIX_W-1:0]  out_first_value_b,
  output logic              out_overflow
);

  logic   accept;
  logic   q_push, q_full, q_pop, q_empty;
  stats_t snap, q_data, res;

  // Accept a pair whenever the totals queue has room for a possible snapshot.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  ipds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pixel_a    (in_pixel_a),
    .pixel_b    (in_pixel_b),
    .last_pixel (in_last_pixel),
    .snap_push  (q_push),
    .snap       (snap)
  );

  ipds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (snap),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  ipds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res),
    .res_mean  (out_mean_difference)
  );

  // Drive result fields from the back end's result register.
  assign out_total_pixels    = res.total;
  assign out_differing_count = res.dcount;
  assign out_max_difference  = res.maxd;
  assign out_any_difference  = res.found;
  assign out_first_index     = res.first_idx;
  assign out_first_value_a   = res.first_a;
  assign out_first_value_b   = res.first_b;
  assign out_overflow        = res.ovf;

  // A snapshot never lands on a full queue.
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("snapshot pushed into full totals queue");

  // Reset leaves no result pending.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  // With no differing pair the mean and first-difference fields are zero.
  a_no_diff_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_differing_count == '0) |->
      (out_mean_difference == '0 && !out_any_difference))
    else $error("nonzero mean without differing pairs");

  a_no_diff_zero_first: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_any_difference) |->
      (out_first_index == '0 && out_first_value_a == '0 && out_first_value_b == '0))
    else $error("first difference reported without any difference");

endmodule

[sim/tb_image_pair_difference_stats_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for image_pair_difference_stats_unit: directed pixel pairs, then
// random images of mixed length and difference density, checked against a totals predictor.
// Depends on ipds_pkg and the unit's RTL only.
module tb_image_pair_difference_stats_unit;
  import ipds_pkg::*;

  localparam int N_ITEMS     = 1450;    // stop starting new images past this many pairs
  localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int TAIL_CYCLES = 120;     // over two divides, catches stray results
  localparam int HOLD_CYCLES = 400;     // long receiver stall, fills the totals queue
  localparam int BURST_FIRST = 12;      // images of 1..3 pairs, no sender gaps
  localparam int BURST_LAST  = 40;
  localparam int DRAIN_IMAGE = 60;      // sender waits here until all results are in
  localparam int N_ROWS      = 20;

  // One result of the unit, as the output ports present it.
  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  dcount;
    logic [MEAN_W-1:0] mean;
    logic [PIX_W-1:0]  maxd;
    logic              any;
    logic [IDX_W-1:0]  first_idx;
    logic [PIX_W-1:0]  first_a;
    logic [PIX_W-1:0]  first_b;
    logic              ovf;
  } image_totals_t;

  // One directed item; typed rows carry a result worked out by hand.
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic             last;
    logic             typed;
    image_totals_t    want;
  } stim_row_t;

  localparam image_totals_t NO_TOTALS = '0;

  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // single-pair images: nothing before the last item
    '{16'h0000, 16'h0000, 1'b1, 1'b1,
      '{25'd1, 25'd0, 24'd0, 16'h0000, 1'b0, 24'd0, 16'h0000, 16'h0000, 1'b0}},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1,
      '{25'd1, 25'd1, 24'hFFFF00, 16'hFFFF, 1'b1, 24'd0, 16'hFFFF, 16'h0000, 1'b0}},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b1,
      '{25'd1, 25'd1, 24'hFFFF00, 16'hFFFF, 1'b1, 24'd0, 16'h0000, 16'hFFFF, 1'b0}},
    '{16'h0001, 16'h0000, 1'b1, 1'b1,
      '{25'd1, 25'd1, 24'd256, 16'h0001, 1'b1, 24'd0, 16'h0001, 16'h0000, 1'b0}},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b1,
      '{25'd1, 25'd1, 24'd256, 16'h0001, 1'b1, 24'd0, 16'h8000, 16'h7FFF, 1'b0}},
    // first difference after two equal pairs
    '{16'hAAAA, 16'hAAAA, 1'b0, 1'b0, NO_TOTALS},
    '{16'h5555, 16'h5555, 1'b0, 1'b0, NO_TOTALS},
    '{16'h1234, 16'h1236, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0000, 16'h0003, 1'b0, 1'b0, NO_TOTALS},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, NO_TOTALS},
    // mean that truncates: 4 * 256 / 3
    '{16'h0010, 16'h0011, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0011, 16'h0010, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0000, 16'h0002, 1'b1, 1'b0, NO_TOTALS},
    // an identical image of three pairs: no difference at all
    '{16'h0007, 16'h0007, 1'b0, 1'b0, NO_TOTALS},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0000, 16'h0000, 1'b1, 1'b1,
      '{25'd3, 25'd0, 24'd0, 16'h0000, 1'b0, 24'd0, 16'h0000, 16'h0000, 1'b0}},
    // largest difference first and again, smaller ones after it
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, NO_TOTALS},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0100, 16'h0000, 1'b0, 1'b0, NO_TOTALS},
    '{16'h0000, 16'h0000, 1'b1, 1'b0, NO_TOTALS}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [PIX_W-1:0]  in_pixel_a = '0;
  logic [PIX_W-1:0]  in_pixel_b = '0;
  logic              in_last_pixel = 1'b0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [CNT_W-1:0]  out_total_pixels;
  logic [CNT_W-1:0]  out_differing_count;
  logic [MEAN_W-1:0] out_mean_difference;
  logic [PIX_W-1:0]  out_max_difference;
  logic              out_any_difference;
  logic [IDX_W-1:0]  out_first_index;
  logic [PIX_W-1:0]  out_first_value_a;
  logic [PIX_W-1:0]  out_first_value_b;
  logic              out_overflow;

  image_totals_t pending_totals [$];  // results owed by images already pushed
  int            items_sent = 0;
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            hold_results = 1'b0;  // sender asks the receiver for its long stall

  // Running totals of the image in flight, as the unit should hold them.
  logic [CNT_W-1:0] acc_total;
  logic [CNT_W-1:0] acc_dcount;
  logic [SUM_W-1:0] acc_sum;
  logic [PIX_W-1:0] acc_maxd;
  logic             acc_found;
  logic [IDX_W-1:0] acc_first_idx;
  logic [PIX_W-1:0] acc_first_a;
  logic [PIX_W-1:0] acc_first_b;
  logic             acc_ovf;

  image_pair_difference_stats_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_pixel_a          (in_pixel_a),
    .in_pixel_b          (in_pixel_b),
    .in_last_pixel       (in_last_pixel),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_total_pixels    (out_total_pixels),
    .out_differing_count (out_differing_count),
    .out_mean_difference (out_mean_difference),
    .out_max_difference  (out_max_difference),
    .out_any_difference  (out_any_difference),
    .out_first_index     (out_first_index),
    .out_first_value_a   (out_first_value_a),
    .out_first_value_b   (out_first_value_b),
    .out_overflow        (out_overflow)
  );

  always #2 clk = ~clk;

  // Bound the run; a hang or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still pending", $time, pending_totals.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void clear_totals();
    acc_total     = '0;
    acc_dcount    = '0;
    acc_sum       = '0;
    acc_maxd      = '0;
    acc_found     = 1'b0;
    acc_first_idx = '0;
    acc_first_a   = '0;
    acc_first_b   = '0;
    acc_ovf       = 1'b0;
  endfunction

  // Fold one pair into the running totals; on the last pair of an image hand
  // back the result and clear for the next image.
  function automatic logic absorb_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                       input logic last, output image_totals_t res);
    logic [PIX_W-1:0] diff;
    logic [IDX_W-1:0] idx;
    logic [SUM_W:0]   wide_sum;
    logic [DVD_W-1:0] quot;
    diff = (a > b) ? a - b : b - a;
    res  = '0;
    // a saturated count pins the index at the top of the range
    if (acc_total < CAP) begin
      idx       = acc_total[IDX_W-1:0];
      acc_total = acc_total + CNT_W'(1);
    end else begin
      idx     = '1;
      acc_ovf = 1'b1;
    end
    // equal pairs leave everything but the count and the overflow flag alone
    if (diff != '0) begin
      wide_sum = {1'b0, acc_sum} + (SUM_W+1)'(diff);
      if (wide_sum[SUM_W]) begin
        acc_sum = '1;
        acc_ovf = 1'b1;
      end else begin
        acc_sum = wide_sum[SUM_W-1:0];
      end
      if (diff > acc_maxd) acc_maxd = diff;
      if (acc_dcount < CAP) acc_dcount = acc_dcount + CNT_W'(1);
      else acc_ovf = 1'b1;
      if (!acc_found) begin
        acc_found     = 1'b1;
        acc_first_idx = idx;
        acc_first_a   = a;
        acc_first_b   = b;
      end
    end
    if (!last) return 1'b0;
    // mean in Q16.8, truncated; zero when nothing differed
    quot = '0;
    if (acc_dcount != '0) quot = {acc_sum, {FRAC_W{1'b0}}} / DVD_W'(acc_dcount);
    res.total     = acc_total;
    res.dcount    = acc_dcount;
    res.mean      = quot[MEAN_W-1:0];
    res.maxd      = acc_maxd;
    res.any       = acc_found;
    res.first_idx = acc_first_idx;
    res.first_a   = acc_first_a;
    res.first_b   = acc_first_b;
    res.ovf       = acc_ovf;
    clear_totals();
    return 1'b1;
  endfunction

  // Offer one pair after a random gap unless quiet, and hold it until taken. Push
  // stays high between back-to-back items so it never drops and rises within one step.
  task automatic push_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                           input logic last, input bit quiet, input bit typed,
                           input image_totals_t want);
    int gap;
    image_totals_t res;
    gap = quiet ? 0 : $urandom_range(4);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_pixel_a    <= a;
    in_pixel_b    <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    // a typed row replaces the predicted result but still clears the predictor
    if (absorb_pair(a, b, last, res)) pending_totals.push_back(typed ? want : res);
  endtask

  // Send one image with a difference pattern drawn for the whole image.
  task automatic send_image(input int len, input bit quiet);
    int kind;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    kind = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) a = $urandom_range(1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      else a = PIX_W'($urandom);
      case (kind)
        0:       b = a;                                                  // identical
        1:       b = ($urandom_range(9) == 0) ? PIX_W'($urandom) : a;    // sparse
        2:       b = ($urandom_range(7) == 0) ? ~a : PIX_W'($urandom);   // dense
        default: b = a + PIX_W'($urandom_range(4)) - PIX_W'(2);          // small noise
      endcase
      push_pair(a, b, i == len - 1, quiet, 1'b0, NO_TOTALS);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare one accepted result against the oldest owed one.
  task automatic check_totals(input image_totals_t got);
    image_totals_t want;
    if (pending_totals.size() == 0) begin
      $display("%0t ns: result with no image pending, expected none, got %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_totals.pop_front();
    check_field("total_pixels",    64'(want.total),     64'(got.total));
    check_field("differing_count", 64'(want.dcount),    64'(got.dcount));
    check_field("mean_difference", 64'(want.mean),      64'(got.mean));
    check_field("max_difference",  64'(want.maxd),      64'(got.maxd));
    check_field("any_difference",  64'(want.any),       64'(got.any));
    check_field("first_index",     64'(want.first_idx), 64'(got.first_idx));
    check_field("first_value_a",   64'(want.first_a),   64'(got.first_a));
    check_field("first_value_b",   64'(want.first_b),   64'(got.first_b));
    check_field("overflow",        64'(want.ovf),       64'(got.ovf));
  endtask

  // Result side: pop with random gaps, runs of back-to-back pops, and one long
  // stall on request so the queue fills and the input backs up.
  initial begin : result_drain
    int gap;
    int calm_left;
    bit hold_done;
    image_totals_t got;
    calm_left = 0;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results && !hold_done) begin
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        if ($urandom_range(5) == 0) calm_left = 8;
        gap = $urandom_range(4);
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got.total     = out_total_pixels;
      got.dcount    = out_differing_count;
      got.mean      = out_mean_difference;
      got.maxd      = out_max_difference;
      got.any       = out_any_difference;
      got.first_idx = out_first_index;
      got.first_a   = out_first_value_a;
      got.first_b   = out_first_value_b;
      got.ovf       = out_overflow;
      check_totals(got);
    end
  end

  // Input side: reset, directed rows, then random images until the item
  // budget is spent; the last image always runs to its last pair.
  initial begin : pixel_source
    int img;
    int len;
    bit quiet;
    clear_totals();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++)
      push_pair(DIR_ROWS[r].a, DIR_ROWS[r].b, DIR_ROWS[r].last, 1'b0,
                DIR_ROWS[r].typed, DIR_ROWS[r].want);

    img = 0;
    while (items_sent < N_ITEMS) begin
      img++;
      if (img == BURST_FIRST) hold_results = 1'b1;
      if (img >= BURST_FIRST && img <= BURST_LAST) begin
        // tiny images at full rate while results are held off
        len   = $urandom_range(1, 3);
        quiet = 1'b1;
      end else begin
        quiet = ($urandom_range(3) == 0);
        case ($urandom_range(9))
          0:       len = 1;
          7, 8:    len = $urandom_range(41, 120);
          9:       len = $urandom_range(121, 300);
          default: len = $urandom_range(2, 40);
        endcase
      end
      if (img == DRAIN_IMAGE) begin
        // drop push and let every owed result come out first
        in_push <= 1'b0;
        @(posedge clk);
        while (pending_totals.size() != 0) @(posedge clk);
      end
      send_image(len, quiet);
    end
    in_push <= 1'b0;

    while (pending_totals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
